@@ rtl/core/lrs_pkg.sv @@
`default_nettype none

package lrs_pkg;

  localparam int unsigned HEADER_BYTES = 27;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_BAD_CRC = 2'd2;
  localparam logic [1:0] ST_EOL     = 2'd3;

  // replay actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SCAN_MODE     = 2'd0;
  localparam logic [1:0] CFG_COMMIT_OPCODE = 2'd1;
  localparam logic [1:0] CFG_INSERT_OPCODE = 2'd2;
  localparam logic [1:0] CFG_DELETE_OPCODE = 2'd3;

  localparam logic       MODE_COMMIT = 1'b0;
  localparam logic [7:0] COMMIT_OPCODE_RST = 8'd3;
  localparam logic [7:0] INSERT_OPCODE_RST = 8'd1;
  localparam logic [7:0] DELETE_OPCODE_RST = 8'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // status of the commit bitmap
  typedef struct packed {
    logic busy;       // clearing pass running
    logic clean;      // every bit known to be zero
    logic init_done;  // first pass after reset finished
  } map_status_t;

  // one byte of reflected CRC-32C, bit at a time
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] c;
    c = crc ^ {24'd0, d};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lrs_commit_map.sv @@
`default_nettype none

module lrs_commit_map import lrs_pkg::*; #(
  parameter int unsigned TXN_SLOTS = 1024,
  parameter int unsigned IDX_W     = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             sweep_start,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic                  rd_bit,
  output map_status_t           status
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TXN_SLOTS - 1);

  logic             mem [TXN_SLOTS];
  logic             busy_r, clean_r, init_done_r;
  logic [IDX_W-1:0] idx_r;
  logic             rd_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      clean_r     <= 1'b0;
      init_done_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          busy_r      <= 1'b0;
          clean_r     <= 1'b1;
          init_done_r <= 1'b1;
        end
      end else if (sweep_start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end
      if (wr_en) begin
        clean_r <= 1'b0;
      end
    end
  end

  // clearing pass and commit marks share the single write port
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[idx_r] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= 1'b1;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_bit = rd_q_r;
  assign status = '{busy: busy_r, clean: clean_r, init_done: init_done_r};

endmodule

`default_nettype wire

@@ rtl/core/log_record_scanner_crc32c_unit.sv @@
// Log record deframer with CRC-32C check. Takes one log byte per clock unless
// stalled and reports one item per record (27-byte little-endian header,
// CRC-32C over the length field to the record end), one item per halted or
// unfinished stream end. Bytes pass an input register and the CRC/header
// logic into the result register; one byte per cycle is sustained unless
// input is stalled, set by the byte-wide CRC update. The commit bitmap is a
// TXN_SLOTS x 1 memory; after reset, and before the first byte of a
// commit-mode stream when any bit was set, a clearing pass runs while input
// is stalled. The bitmap read for replay flags is issued once the transaction
// id is in, so records of any valid length keep the full byte rate.
`default_nettype none

module log_record_scanner_crc32c_unit import lrs_pkg::*; #(
  parameter int unsigned TXN_SLOTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_stream_done,
  output logic [31:0]      out_record_offset,
  output logic [63:0]      out_sequence_number,
  output logic [31:0]      out_transaction_id,
  output logic [7:0]       out_opcode,
  output logic [15:0]      out_key_length,
  output logic [31:0]      out_value_length,
  output logic [1:0]       out_replay_action,
  output logic [15:0]      out_committed_total,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int unsigned IDX_W  = (TXN_SLOTS > 1) ? $clog2(TXN_SLOTS) : 1;
  localparam logic [31:0] SLOTS32 = 32'(TXN_SLOTS);
  localparam logic [31:0] HDR32   = 32'(HEADER_BYTES);

  // configuration
  logic       mode_r;
  logic [7:0] commit_op_r, insert_op_r, delete_op_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_COMMIT;
      commit_op_r <= COMMIT_OPCODE_RST;
      insert_op_r <= INSERT_OPCODE_RST;
      delete_op_r <= DELETE_OPCODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCAN_MODE:     mode_r      <= cfg_data[0];
        CFG_COMMIT_OPCODE: commit_op_r <= cfg_data;
        CFG_INSERT_OPCODE: insert_op_r <= cfg_data;
        CFG_DELETE_OPCODE: delete_op_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and input register
  logic        s1_valid_r, s1_first_r, s1_last_r;
  logic [7:0]  s1_data_r;
  logic        acc_open_r;
  logic        out_valid_r;
  logic        out_free, s1_go, in_acc, has_res;
  map_status_t map_st;
  logic        map_block, sweep_start;
  logic        map_wr;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && out_free;
  // a mark still leaving the pipe makes the bitmap dirty for the next stream
  assign map_block = !map_st.init_done || map_st.busy ||
                     (!acc_open_r && (mode_r == MODE_COMMIT) && (!map_st.clean || map_wr));
  assign in_stall  = (s1_valid_r && !out_free) || map_block;
  assign in_acc    = in_valid && !in_stall;
  // clear after reset, or once a commit-mode stream is waiting and the pipe is empty
  assign sweep_start = !map_st.busy && !s1_valid_r &&
                       (!map_st.init_done ||
                        (in_valid && !acc_open_r && (mode_r == MODE_COMMIT) && !map_st.clean));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      acc_open_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        acc_open_r <= !in_last_byte;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r  <= in_data_byte;
      s1_last_r  <= in_last_byte;
      s1_first_r <= !acc_open_r;
    end
  end

  // scan state
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] bir_r, bir_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        halted_r, halted_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [31:0] stored_r, stored_nxt;
  logic [31:0] tl_r, tl_nxt;
  logic [63:0] seq_r, seq_nxt;
  logic [31:0] tid_r, tid_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [15:0] klen_r, klen_nxt;
  logic [31:0] vlen_r, vlen_nxt;

  logic        bm_bit;
  logic        bm_wr;

  // result fields
  logic [1:0]  res_status, res_action;
  logic        res_hdr;

  logic [31:0] crc_upd, b_inc;
  logic [4:0]  b5, v_off;
  logic        bad_len, rec_end, rec_ok, has_rec, tid_ok;
  logic [15:0] cnt_base;

  always_comb begin
    crc_upd = crc32c_byte(crc_r, s1_data_r);
    b_inc   = bir_r + 32'd1;
    b5      = bir_r[4:0];
    v_off   = b5 - 5'd23;

    stored_nxt = stored_r;
    tl_nxt     = tl_r;
    seq_nxt    = seq_r;
    tid_nxt    = tid_r;
    op_nxt     = op_r;
    klen_nxt   = klen_r;
    vlen_nxt   = vlen_r;

    // drop the byte into its header field
    if (!halted_r && (bir_r < HDR32)) begin
      if (b5 inside {[5'd0:5'd3]}) begin
        stored_nxt[8*b5[1:0] +: 8] = s1_data_r;
      end else if (b5 inside {[5'd4:5'd7]}) begin
        tl_nxt[8*b5[1:0] +: 8] = s1_data_r;
      end else if (b5 inside {[5'd8:5'd15]}) begin
        seq_nxt[8*b5[2:0] +: 8] = s1_data_r;
      end else if (b5 inside {[5'd16:5'd19]}) begin
        tid_nxt[8*b5[1:0] +: 8] = s1_data_r;
      end else if (b5 == 5'd20) begin
        op_nxt = s1_data_r;
      end else if (b5 inside {[5'd21:5'd22]}) begin
        klen_nxt[8*(b5 == 5'd22) +: 8] = s1_data_r;
      end else begin
        vlen_nxt[8*v_off[1:0] +: 8] = s1_data_r;
      end
    end

    crc_nxt    = crc_r;
    bir_nxt    = bir_r;
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    bad_len    = 1'b0;
    rec_end    = 1'b0;

    if (!halted_r) begin
      crc_nxt = (bir_r >= 32'd4) ? crc_upd : crc_r;
      bir_nxt = b_inc;
      if ((b_inc == HDR32) && (tl_nxt < HDR32)) begin
        bad_len = 1'b1;
      end else if ((b_inc >= HDR32) && (b_inc == tl_nxt)) begin
        rec_end = 1'b1;
      end
    end

    rec_ok  = rec_end && ((crc_nxt ^ CRC_ONES) == stored_nxt);
    has_rec = bad_len || rec_end;
    tid_ok  = tid_nxt < SLOTS32;

    cnt_base = (s1_first_r && (mode_r == MODE_COMMIT)) ? 16'd0 : cnt_r;
    cnt_nxt  = cnt_base;
    bm_wr    = 1'b0;
    res_action = ACT_NONE;

    if (rec_ok) begin
      if (mode_r == MODE_COMMIT) begin
        if ((op_nxt == commit_op_r) && tid_ok) begin
          bm_wr = 1'b1;
          if (cnt_base != COUNT_MAX) begin
            cnt_nxt = cnt_base + 16'd1;
          end
        end
      end else if (tid_ok && bm_bit) begin
        if (op_nxt == insert_op_r) begin
          res_action = ACT_INSERT;
        end else if (op_nxt == delete_op_r) begin
          res_action = ACT_DELETE;
        end
      end
      pos_nxt = pos_r + tl_nxt;
      crc_nxt = CRC_ONES;
      bir_nxt = '0;
    end else if (has_rec) begin
      halted_nxt = 1'b1;
    end

    if (bad_len) begin
      res_status = ST_BAD_LEN;
    end else if (rec_end && !rec_ok) begin
      res_status = ST_BAD_CRC;
    end else if (rec_end) begin
      res_status = ST_OK;
    end else begin
      res_status = ST_EOL;
    end
    res_hdr = has_rec;
    has_res = has_rec || s1_last_r;

    // stream end: back to the start of a fresh log
    if (s1_last_r) begin
      crc_nxt    = CRC_ONES;
      bir_nxt    = '0;
      pos_nxt    = '0;
      halted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_ONES;
      bir_r    <= '0;
      pos_r    <= '0;
      halted_r <= 1'b0;
      cnt_r    <= '0;
    end else if (s1_go) begin
      crc_r    <= crc_nxt;
      bir_r    <= bir_nxt;
      pos_r    <= pos_nxt;
      halted_r <= halted_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      stored_r <= stored_nxt;
      tl_r     <= tl_nxt;
      seq_r    <= seq_nxt;
      tid_r    <= tid_nxt;
      op_r     <= op_nxt;
      klen_r   <= klen_nxt;
      vlen_r   <= vlen_nxt;
    end
  end

  assign map_wr = s1_go && bm_wr;

  lrs_commit_map #(
    .TXN_SLOTS (TXN_SLOTS),
    .IDX_W     (IDX_W)
  ) u_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .sweep_start (sweep_start),
    .wr_en       (map_wr),
    .wr_addr     (tid_nxt[IDX_W-1:0]),
    .rd_addr     (tid_r[IDX_W-1:0]),
    .rd_bit      (bm_bit),
    .status      (map_st)
  );

  // result register
  logic [1:0]  out_status_r, out_action_r;
  logic        out_done_r;
  logic [31:0] out_offset_r, out_tid_r, out_vlen_r;
  logic [63:0] out_seq_r;
  logic [7:0]  out_op_r;
  logic [15:0] out_klen_r, out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (s1_go && has_res) || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_res) begin
      out_status_r <= res_status;
      out_done_r   <= s1_last_r;
      out_offset_r <= pos_r;
      out_seq_r    <= res_hdr ? seq_nxt  : '0;
      out_tid_r    <= res_hdr ? tid_nxt  : '0;
      out_op_r     <= res_hdr ? op_nxt   : '0;
      out_klen_r   <= res_hdr ? klen_nxt : '0;
      out_vlen_r   <= res_hdr ? vlen_nxt : '0;
      out_action_r <= res_action;
      out_total_r  <= cnt_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_stream_done     = out_done_r;
  assign out_record_offset   = out_offset_r;
  assign out_sequence_number = out_seq_r;
  assign out_transaction_id  = out_tid_r;
  assign out_opcode          = out_op_r;
  assign out_key_length      = out_klen_r;
  assign out_value_length    = out_vlen_r;
  assign out_replay_action   = out_action_r;
  assign out_committed_total = out_total_r;

endmodule

`default_nettype wire

@@ sim/tb_log_record_scanner_crc32c_unit.sv @@
`default_nettype none

module tb_log_record_scanner_crc32c_unit;
  import lrs_pkg::*;

  localparam int unsigned TXN_SLOTS = 1024;
  localparam int unsigned QUIET_LIMIT = 6000;
  localparam int unsigned RANDOM_BYTES = 900;

  // record shapes for the stream builder
  localparam int REC_GOOD    = 0;
  localparam int REC_BAD_LEN = 1;
  localparam int REC_BAD_CRC = 2;
  localparam int REC_HUGE    = 3;

  // receiver stall patterns
  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;

  typedef struct packed {
    logic [1:0]  status;
    logic        done;
    logic [31:0] offset;
    logic [63:0] seq;
    logic [31:0] tid;
    logic [7:0]  op;
    logic [15:0] klen;
    logic [31:0] vlen;
    logic [1:0]  action;
    logic [15:0] total;
  } rec_report_t;

  class record_scoreboard;
    logic        mode;
    logic [7:0]  op_commit, op_insert, op_delete;
    logic [31:0] crc, rec_bytes, rec_start;
    logic [7:0]  hdr[HEADER_BYTES];
    logic        txn_map[TXN_SLOTS];
    logic [15:0] commits;
    logic        halted, opened;
    rec_report_t reports_q[$];
    int          errors, shown;

    function new();
      mode = MODE_COMMIT;
      op_commit = COMMIT_OPCODE_RST;
      op_insert = INSERT_OPCODE_RST;
      op_delete = DELETE_OPCODE_RST;
      foreach (txn_map[i]) txn_map[i] = 1'b0;
      commits = '0;
      errors = 0;
      shown = 0;
      close_stream();
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
      logic [31:0] r;
      r = c ^ {24'd0, d};
      repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
      return r;
    endfunction

    function void clear_scan();
      crc = CRC_ONES;
      rec_bytes = '0;
      foreach (hdr[i]) hdr[i] = 8'h00;
    endfunction

    function void close_stream();
      clear_scan();
      rec_start = '0;
      halted = 1'b0;
      opened = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_SCAN_MODE:     mode = val[0];
        CFG_COMMIT_OPCODE: op_commit = val;
        CFG_INSERT_OPCODE: op_insert = val;
        CFG_DELETE_OPCODE: op_delete = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] field(int off, int n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++) v |= 64'(hdr[off + i]) << (8 * i);
      return v;
    endfunction

    function rec_report_t header_report(logic [1:0] st);
      rec_report_t r;
      r = '0;
      r.status = st;
      r.offset = rec_start;
      r.seq    = field(8, 8);
      r.tid    = 32'(field(16, 4));
      r.op     = 8'(field(20, 1));
      r.klen   = 16'(field(21, 2));
      r.vlen   = 32'(field(23, 4));
      return r;
    endfunction

    // advance the deframer by one accepted byte, queue any report it causes
    function void scan_byte(logic [7:0] d, logic last);
      rec_report_t r;
      logic        have;
      logic [31:0] tl, tid;
      logic [7:0]  op;
      r = '0;
      have = 1'b0;
      if (!opened) begin
        opened = 1'b1;
        if (mode == MODE_COMMIT) begin
          foreach (txn_map[i]) txn_map[i] = 1'b0;
          commits = '0;
        end
      end
      if (!halted) begin
        if (rec_bytes < HEADER_BYTES) hdr[rec_bytes] = d;
        if (rec_bytes >= 4) crc = crc_step(crc, d);
        rec_bytes = rec_bytes + 1;
        if (rec_bytes >= HEADER_BYTES) begin
          tl = 32'(field(4, 4));
          if (rec_bytes == HEADER_BYTES && tl < HEADER_BYTES) begin
            r = header_report(ST_BAD_LEN);
            halted = 1'b1;
            have = 1'b1;
          end else if (rec_bytes == tl) begin
            if ((crc ^ CRC_ONES) != 32'(field(0, 4))) begin
              r = header_report(ST_BAD_CRC);
              halted = 1'b1;
            end else begin
              tid = 32'(field(16, 4));
              op = 8'(field(20, 1));
              r = header_report(ST_OK);
              if (mode == MODE_COMMIT) begin
                if (op == op_commit && tid < TXN_SLOTS) begin
                  txn_map[tid[9:0]] = 1'b1;
                  if (commits != COUNT_MAX) commits = commits + 1;
                end
              end else if (tid < TXN_SLOTS && txn_map[tid[9:0]]) begin
                if (op == op_insert) r.action = ACT_INSERT;
                else if (op == op_delete) r.action = ACT_DELETE;
              end
              rec_start = rec_start + tl;
              clear_scan();
            end
            have = 1'b1;
          end
        end
      end
      if (last) begin
        if (!have) begin
          r = '0;
          r.status = ST_EOL;
          r.offset = rec_start;
          have = 1'b1;
        end
        r.done = 1'b1;
      end
      if (have) begin
        r.total = commits;
        reports_q.push_back(r);
      end
      if (last) close_stream();
    endfunction

    function string show(rec_report_t r);
      return $sformatf({"st=%0d done=%0d off=%h seq=%h tid=%h op=%h klen=%h vlen=%h",
                        " act=%0d tot=%0d"},
                       r.status, r.done, r.offset, r.seq, r.tid, r.op, r.klen, r.vlen,
                       r.action, r.total);
    endfunction

    function void match_report(rec_report_t got);
      rec_report_t want;
      if (reports_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected report: %s", show(got));
        end
        return;
      end
      want = reports_q.pop_front();
      if (got !== want) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("report mismatch, expected %s", show(want));
          $display("                 actual   %s", show(got));
        end
      end
    endfunction

    function int outstanding();
      return reports_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_stream_done;
  logic [31:0] out_record_offset;
  logic [63:0] out_sequence_number;
  logic [31:0] out_transaction_id;
  logic [7:0]  out_opcode;
  logic [15:0] out_key_length;
  logic [31:0] out_value_length;
  logic [1:0]  out_replay_action;
  logic [15:0] out_committed_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_SCAN_MODE;
  logic [7:0]  cfg_data = 8'h00;

  log_record_scanner_crc32c_unit #(.TXN_SLOTS(TXN_SLOTS)) u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  record_scoreboard sb;
  logic [8:0]  stream_q[$];     // {last, data}
  logic [7:0]  cur_commit = COMMIT_OPCODE_RST;
  logic [7:0]  cur_insert = INSERT_OPCODE_RST;
  logic [7:0]  cur_delete = DELETE_OPCODE_RST;
  logic        gaps_on = 1'b0;
  int          burst_left = 0;
  int          stall_mode = STALL_NONE;
  int unsigned stall_tick = 0;
  int unsigned quiet = 0;

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= (stall_tick % 13) < 5;
      default:        out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.scan_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall)
        sb.match_report({out_status, out_stream_done, out_record_offset, out_sequence_number,
                         out_transaction_id, out_opcode, out_key_length, out_value_length,
                         out_replay_action, out_committed_total});
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // hold valid until the register is taken; caller lowers it
  task automatic cfg_put(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic mode, input logic [7:0] c, input logic [7:0] i,
                              input logic [7:0] d);
    cfg_put(CFG_SCAN_MODE, {7'($urandom), mode});
    cfg_put(CFG_COMMIT_OPCODE, c);
    cfg_put(CFG_INSERT_OPCODE, i);
    cfg_put(CFG_DELETE_OPCODE, d);
    cfg_valid <= 1'b0;
    cur_commit = c;
    cur_insert = i;
    cur_delete = d;
  endtask

  task automatic add_record(input int kind, input logic [31:0] tid, input logic [7:0] op,
                            input int plen);
    logic [7:0]  rec[$];
    logic [31:0] tl, crc;
    logic [63:0] seq;
    logic [15:0] klen;
    logic [31:0] vlen;
    seq = {$urandom, $urandom};
    klen = 16'($urandom);
    vlen = $urandom;
    case (kind)
      REC_BAD_LEN: tl = 32'(plen);
      REC_HUGE:    tl = 32'hFFFF_FFFF;
      default:     tl = 32'(HEADER_BYTES) + 32'(plen);
    endcase
    repeat (4) rec.push_back(8'h00);
    for (int k = 0; k < 4; k++) rec.push_back(tl[8*k +: 8]);
    for (int k = 0; k < 8; k++) rec.push_back(seq[8*k +: 8]);
    for (int k = 0; k < 4; k++) rec.push_back(tid[8*k +: 8]);
    rec.push_back(op);
    for (int k = 0; k < 2; k++) rec.push_back(klen[8*k +: 8]);
    for (int k = 0; k < 4; k++) rec.push_back(vlen[8*k +: 8]);
    if (kind != REC_BAD_LEN) repeat (plen) rec.push_back(8'($urandom));
    crc = CRC_ONES;
    for (int k = 4; k < rec.size(); k++) crc = record_scoreboard::crc_step(crc, rec[k]);
    crc = crc ^ CRC_ONES;
    if (kind == REC_BAD_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    for (int k = 0; k < 4; k++) rec[k] = crc[8*k +: 8];
    foreach (rec[k]) stream_q.push_back({1'b0, rec[k]});
  endtask

  task automatic add_random_record(input logic mode);
    logic [31:0] tid;
    logic [7:0]  op;
    int          pick, plen;
    pick = $urandom_range(0, 9);
    if (pick < 7) tid = $urandom_range(0, 15);
    else if (pick == 7) tid = TXN_SLOTS - 1;
    else if (pick == 8) tid = TXN_SLOTS;
    else tid = $urandom;
    case ($urandom_range(0, 4))
      0, 1:    op = (mode == MODE_COMMIT) ? cur_commit : cur_insert;
      2:       op = cur_delete;
      3:       op = cur_insert;
      default: op = 8'($urandom);
    endcase
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
    pick = $urandom_range(0, 99);
    if (pick < 80) add_record(REC_GOOD, tid, op, plen);
    else if (pick < 88) add_record(REC_BAD_CRC, tid, op, plen);
    else if (pick < 94) add_record(REC_BAD_LEN, tid, op, $urandom_range(0, 26));
    else repeat ($urandom_range(1, 20)) stream_q.push_back({1'b0, 8'($urandom)});
  endtask

  // append trailing bytes and mark the final byte of the stream
  task automatic seal_stream(input int junk);
    repeat (junk) stream_q.push_back({1'b0, 8'($urandom)});
    if (stream_q.size() == 0) stream_q.push_back({1'b0, 8'($urandom)});
    stream_q[stream_q.size() - 1][8] = 1'b1;
  endtask

  // drive the queued stream, then wait for its reports and let the block settle
  task automatic send_stream();
    logic [8:0] item;
    while (stream_q.size() > 0) begin
      item = stream_q.pop_front();
      if (gaps_on && burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 40);
      end
      in_valid <= 1'b1;
      in_data_byte <= item[7:0];
      in_last_byte <= item[8];
      do @(posedge clk); while (in_stall);
      @(negedge clk);
      if (burst_left > 0) burst_left--;
    end
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int unsigned sent;
    logic        mode;
    logic [7:0]  c, i, d;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed streams
    program_regs(MODE_COMMIT, COMMIT_OPCODE_RST, INSERT_OPCODE_RST, DELETE_OPCODE_RST);
    seal_stream(0);
    send_stream();

    add_record(REC_GOOD, 5, COMMIT_OPCODE_RST, 4);
    add_record(REC_GOOD, TXN_SLOTS - 1, COMMIT_OPCODE_RST, 0);
    add_record(REC_GOOD, TXN_SLOTS, COMMIT_OPCODE_RST, 2);
    add_record(REC_GOOD, 32'hFFFF_FFFF, COMMIT_OPCODE_RST, 1);
    add_record(REC_GOOD, 5, INSERT_OPCODE_RST, 1);
    add_record(REC_BAD_CRC, 7, COMMIT_OPCODE_RST, 3);
    seal_stream(4);
    send_stream();

    program_regs(1'b1, COMMIT_OPCODE_RST, INSERT_OPCODE_RST, DELETE_OPCODE_RST);
    add_record(REC_GOOD, 5, INSERT_OPCODE_RST, 0);
    add_record(REC_GOOD, TXN_SLOTS - 1, DELETE_OPCODE_RST, 5);
    add_record(REC_GOOD, 6, INSERT_OPCODE_RST, 0);
    add_record(REC_GOOD, TXN_SLOTS, INSERT_OPCODE_RST, 0);
    add_record(REC_GOOD, 5, COMMIT_OPCODE_RST, 0);
    seal_stream(0);
    send_stream();

    add_record(REC_BAD_LEN, 9, INSERT_OPCODE_RST, 0);
    seal_stream(3);
    send_stream();

    add_record(REC_GOOD, 5, DELETE_OPCODE_RST, 2);
    add_record(REC_BAD_LEN, 5, INSERT_OPCODE_RST, 26);
    seal_stream(0);
    send_stream();

    add_record(REC_GOOD, 5, INSERT_OPCODE_RST, 1);
    add_record(REC_HUGE, 5, INSERT_OPCODE_RST, 6);
    seal_stream(0);
    send_stream();

    // random streams
    sent = 0;
    mode = MODE_COMMIT;
    c = COMMIT_OPCODE_RST;
    i = INSERT_OPCODE_RST;
    d = DELETE_OPCODE_RST;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: begin c = COMMIT_OPCODE_RST; i = INSERT_OPCODE_RST; d = DELETE_OPCODE_RST; end
          1: begin c = 8'h00; i = 8'hFF; d = 8'h80; end
          2: begin c = 8'hFF; i = 8'h00; d = 8'h00; end
          default: begin c = 8'($urandom); i = 8'($urandom); d = 8'($urandom); end
        endcase
      end
      if ($urandom_range(0, 3) != 0) mode = ~mode;
      program_regs(mode, c, i, d);
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
      repeat ($urandom_range(1, 8)) add_random_record(mode);
      seal_stream(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30));
      sent += stream_q.size();
      send_stream();
    end

    stall_mode = STALL_NONE;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/lrs_pkg.sv
rtl/core/lrs_commit_map.sv
rtl/core/log_record_scanner_crc32c_unit.sv
sim/tb_log_record_scanner_crc32c_unit.sv
